// File: src/tljp_pkg.sv
// ============================================================================
// tljp_pkg
// Shared types, constants and helpers for the Lennard-Jones pair kernel.
// ============================================================================
package tljp_pkg;

    localparam int NUM_TYPES   = 4;
    localparam int TYPE_W      = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_LAT     = 64;
    localparam int MUL_LAT     = 3;
    localparam int TERM_LAT    = 5 * MUL_LAT + 1;
    localparam int PADDR_W     = 5;

    localparam logic [23:0] CUTOFF_RESET = 24'd163840;
    localparam logic [16:0] ROOT6_TWO    = 17'd73562;
    localparam logic [63:0] TOP          = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [40:0] MAG_CAP      = 41'h100_0000_0000;

    localparam logic [1:0] REG_REPULSIVE = 2'd0;
    localparam logic [1:0] REG_CUTOFF    = 2'd1;
    localparam logic [1:0] REG_SIGMA     = 2'd2;
    localparam logic [1:0] REG_REPS      = 2'd3;

    typedef enum logic [2:0] {
        OP_ZERO    = 3'd0,
        OP_OVERLAP = 3'd1,
        OP_E_WCA   = 3'd2,
        OP_E_LJ    = 3'd3,
        OP_FORCE   = 3'd4
    } op_t;

    typedef struct packed {
        logic              func;
        logic [23:0]       distance;
        logic [TYPE_W-1:0] type_a;
        logic [TYPE_W-1:0] type_b;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               overlap;
        logic               saturated;
    } out_item_t;

    // Classified pair handed from the front end to the datapath.
    typedef struct packed {
        op_t         op;
        logic        use_cut;
        logic        cut_zero;
        logic [23:0] pair_dist;
        logic [23:0] cutoff;
        logic [16:0] s13;
        logic [31:0] eps;
    } cls_item_t;

    function automatic logic [15:0] table_word(input logic [63:0] tbl,
                                               input logic [TYPE_W-1:0] t);
        logic [15:0] w;
        w = '0;
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            if (int'(t) == i)
            begin
                w = tbl[16*i +: 16];
            end
        end
        return w;
    endfunction

    function automatic logic [40:0] cap40(input logic [63:0] m);
        return (m > 64'(MAG_CAP)) ? MAG_CAP : m[40:0];
    endfunction

    function automatic logic signed [42:0] to_signed(input logic [40:0] mag,
                                                     input logic neg);
        logic signed [42:0] s;
        s = $signed({2'b00, mag});
        return neg ? -s : s;
    endfunction

endpackage

// File: src/truncated_lj_pair_energy_force.sv
// One bead pair is taken per clock and one result leaves per clock while
// neither a full input queue nor a stalled output holds the flow. A result
// passes through the input queue, the 64-stage sigma/r divider, the 16-stage
// power chain, the 64-stage force divider and the output register. A four-entry
// input queue lets pairs keep arriving while a result waits at the output.
// Registers sit at byte addresses 0, 8, 16 and 24; the user must see that they
// are written only while no pair is in flight, as the block does not enforce it.
// ============================================================================
// truncated_lj_pair_energy_force
// Truncated and shifted Lennard-Jones 12-6 pair energy and force kernel.
// ============================================================================
module truncated_lj_pair_energy_force import tljp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_stall,
    input  in_item_t           item,
    output logic               result_valid,
    input  logic               result_stall,
    output out_item_t          result
);

    cls_item_t cls, head;
    logic      full, empty, pop, push;

    assign pready     = 1'b1;
    assign item_stall = full;
    assign push       = item_valid && !full;

    tljp_front u_front
    (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .item, .cls
    );

    tljp_queue u_queue
    (
        .clk, .rst_n, .push, .wdata(cls), .full, .pop, .head, .empty
    );

    tljp_back u_back
    (
        .clk, .rst_n, .head, .empty, .pop, .result_valid, .result_stall, .result
    );

endmodule

// File: src/tljp_mul.sv
// ============================================================================
// tljp_mul
// 64 by 64 multiply, shifted right and saturated to 64 bits, three stages.
// ============================================================================
module tljp_mul import tljp_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic [5:0]  sh,
    output logic [63:0] p
);

    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] prod_reg;
    logic [5:0]   sh1_reg, sh2_reg;
    logic [63:0]  p_reg;
    logic [127:0] shifted;

    assign shifted = prod_reg >> sh2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg  <= 64'(a[31:0]) * 64'(b[31:0]);
            p01_reg  <= 64'(a[31:0]) * 64'(b[63:32]);
            p10_reg  <= 64'(a[63:32]) * 64'(b[31:0]);
            p11_reg  <= 64'(a[63:32]) * 64'(b[63:32]);
            sh1_reg  <= sh;
            prod_reg <= {p11_reg, p00_reg} + {32'd0, p01_reg, 32'd0}
                        + {32'd0, p10_reg, 32'd0};
            sh2_reg  <= sh1_reg;
            p_reg    <= (|shifted[127:64]) ? TOP : shifted[63:0];
        end
    end

    assign p = p_reg;

endmodule

// File: src/tljp_div.sv
// ============================================================================
// tljp_div
// Pipelined restoring divider: 64-bit dividend over 24-bit divisor,
// one quotient bit per stage.
// ============================================================================
module tljp_div import tljp_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [23:0] den,
    output logic [63:0] quo
);

    logic [23:0] rem_reg [DIV_LAT];
    logic [63:0] num_reg [DIV_LAT];
    logic [23:0] den_reg [DIV_LAT];
    logic [63:0] quo_reg [DIV_LAT];

    logic [23:0] rem_in [DIV_LAT];
    logic [63:0] num_in [DIV_LAT];
    logic [23:0] den_in [DIV_LAT];
    logic [63:0] quo_in [DIV_LAT];
    logic [24:0] trial  [DIV_LAT];
    logic        qbit   [DIV_LAT];
    logic [23:0] rem_nx [DIV_LAT];

    always_comb
    begin
        for (int k = 0; k < DIV_LAT; k++)
        begin
            if (k == 0)
            begin
                rem_in[k] = '0;
                num_in[k] = num;
                den_in[k] = den;
                quo_in[k] = '0;
            end
            else
            begin
                rem_in[k] = rem_reg[k-1];
                num_in[k] = num_reg[k-1];
                den_in[k] = den_reg[k-1];
                quo_in[k] = quo_reg[k-1];
            end
            trial[k] = {rem_in[k], num_in[k][63]};
            qbit[k]  = (trial[k] >= {1'b0, den_in[k]});
            rem_nx[k] = qbit[k] ? 24'(trial[k] - {1'b0, den_in[k]}) : trial[k][23:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_LAT; k++)
            begin
                rem_reg[k] <= rem_nx[k];
                num_reg[k] <= {num_in[k][62:0], 1'b0};
                den_reg[k] <= den_in[k];
                quo_reg[k] <= {quo_in[k][62:0], qbit[k]};
            end
        end
    end

    assign quo = quo_reg[DIV_LAT-1];

endmodule

// File: src/tljp_term.sv
// ============================================================================
// tljp_term
// Power chain of one pair term: q^2, q^6, q^12, their difference (weighted
// when wsel is set) and the product with epsilon, scaled to Q.16.
// ============================================================================
module tljp_term import tljp_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] q,
    input  logic [31:0] eps,
    input  logic        wsel,
    output logic [63:0] m,
    output logic        neg
);

    logic [63:0] q2, q4, q6, q12;
    logic [63:0] q2_d_reg  [MUL_LAT];
    logic [63:0] q6_d_reg  [MUL_LAT];
    logic [31:0] eps_d_reg [4*MUL_LAT+1];
    logic [4*MUL_LAT-1:0] ws_d_reg;
    logic [MUL_LAT-1:0]   neg_d_reg;
    logic [63:0] d_reg;
    logic        neg_reg;

    logic [66:0] a12;
    logic [65:0] b6;
    logic [63:0] a_w, b_w, d_next;
    logic        neg_next;

    tljp_mul u_m2  (.clk, .en, .a(q),  .b(q),  .sh(6'd24), .p(q2));
    tljp_mul u_m4  (.clk, .en, .a(q2), .b(q2), .sh(6'd24), .p(q4));
    tljp_mul u_m6  (.clk, .en, .a(q4), .b(q2_d_reg[MUL_LAT-1]), .sh(6'd24), .p(q6));
    tljp_mul u_m12 (.clk, .en, .a(q6), .b(q6), .sh(6'd24), .p(q12));
    tljp_mul u_me  (.clk, .en, .a(64'(eps_d_reg[4*MUL_LAT])), .b(d_reg),
                    .sh(6'd30), .p(m));

    always_comb
    begin
        a12 = {q12, 3'b000} + {1'b0, q12, 2'b00};
        b6  = {q6_d_reg[MUL_LAT-1], 2'b00} + {1'b0, q6_d_reg[MUL_LAT-1], 1'b0};
        if (ws_d_reg[4*MUL_LAT-1])
        begin
            a_w = (|a12[66:64]) ? TOP : a12[63:0];
            b_w = (|b6[65:64]) ? TOP : b6[63:0];
        end
        else
        begin
            a_w = q12;
            b_w = q6_d_reg[MUL_LAT-1];
        end
        neg_next = 1'b0;
        if (q12 == TOP || a_w == TOP)
        begin
            d_next = TOP;
        end
        else if (a_w >= b_w)
        begin
            d_next = a_w - b_w;
        end
        else
        begin
            d_next   = b_w - a_w;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q2_d_reg[0]  <= q2;
            q6_d_reg[0]  <= q6;
            eps_d_reg[0] <= eps;
            for (int k = 1; k < MUL_LAT; k++)
            begin
                q2_d_reg[k] <= q2_d_reg[k-1];
                q6_d_reg[k] <= q6_d_reg[k-1];
            end
            for (int k = 1; k < 4*MUL_LAT+1; k++)
            begin
                eps_d_reg[k] <= eps_d_reg[k-1];
            end
            ws_d_reg  <= {ws_d_reg[4*MUL_LAT-2:0], wsel};
            d_reg     <= d_next;
            neg_reg   <= neg_next;
            neg_d_reg <= {neg_d_reg[MUL_LAT-2:0], neg_reg};
        end
    end

    assign neg = neg_d_reg[MUL_LAT-1];

endmodule

// File: src/tljp_queue.sv
// ============================================================================
// tljp_queue
// Short queue of classified items between the front end and the datapath.
// ============================================================================
module tljp_queue import tljp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cls_item_t wdata,
    output logic      full,
    input  logic      pop,
    output cls_item_t head,
    output logic      empty
);

    cls_item_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

endmodule

// File: src/tljp_front.sv
// ============================================================================
// tljp_front
// Register file behind the APB port, and classification of incoming pairs.
// ============================================================================
module tljp_front import tljp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    input  in_item_t           item,
    output cls_item_t          cls
);

    logic        repulsive_reg;
    logic [23:0] cutoff_reg;
    logic [63:0] sigma_reg;
    logic [63:0] reps_reg;
    logic [1:0]  idx;

    logic [15:0] sa, sb, ea, eb;
    logic [16:0] s13;
    logic [33:0] wca_lim;
    logic        in_wca, near;

    assign idx = paddr[PADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repulsive_reg <= 1'b0;
            cutoff_reg    <= CUTOFF_RESET;
            sigma_reg     <= '0;
            reps_reg      <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_REPULSIVE: repulsive_reg <= pwdata[0];
                REG_CUTOFF:    cutoff_reg    <= pwdata[23:0];
                REG_SIGMA:     sigma_reg     <= pwdata;
                REG_REPS:      reps_reg      <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_REPULSIVE: prdata = {63'd0, repulsive_reg};
            REG_CUTOFF:    prdata = {40'd0, cutoff_reg};
            REG_SIGMA:     prdata = sigma_reg;
            REG_REPS:      prdata = reps_reg;
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        sa      = table_word(sigma_reg, item.type_a);
        sb      = table_word(sigma_reg, item.type_b);
        ea      = table_word(reps_reg, item.type_a);
        eb      = table_word(reps_reg, item.type_b);
        s13     = {1'b0, sa} + {1'b0, sb};
        wca_lim = 34'(ROOT6_TWO) * 34'(s13);
        // The WCA range ends at 2^(1/6) sigma; both sides carry Q.29 scaling.
        in_wca  = ({item.distance, 13'd0} < 37'(wca_lim));
        near    = (item.distance < cutoff_reg);

        cls.use_cut   = 1'b0;
        cls.cut_zero  = (cutoff_reg == '0) && (s13 == '0);
        cls.pair_dist = item.distance;
        cls.cutoff    = cutoff_reg;
        cls.s13       = s13;
        cls.eps       = 32'(ea) * 32'(eb);

        if (item.distance == '0)
        begin
            cls.op = OP_OVERLAP;
        end
        else if (repulsive_reg)
        begin
            if (!in_wca)
            begin
                cls.op = OP_ZERO;
            end
            else
            begin
                cls.op = item.func ? OP_FORCE : OP_E_WCA;
            end
        end
        else if (near)
        begin
            cls.op = item.func ? OP_FORCE : OP_E_LJ;
        end
        else if (item.func)
        begin
            // Beyond the cutoff the force is taken at q = sigma / cutoff.
            cls.op      = OP_FORCE;
            cls.use_cut = 1'b1;
        end
        else
        begin
            cls.op = OP_ZERO;
        end
    end

endmodule

// File: src/tljp_back.sv
// ============================================================================
// tljp_back
// Datapath: sigma/r ratios, two power-chain lanes, force division and
// final saturation into the output register.
// ============================================================================
module tljp_back import tljp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cls_item_t head,
    input  logic      empty,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    typedef struct packed {
        op_t         op;
        logic        use_cut;
        logic        cut_zero;
        logic [31:0] eps;
        logic [23:0] pair_dist;
    } sba_t;

    typedef struct packed {
        op_t         op;
        logic [23:0] eps_sh;
        logic [23:0] pair_dist;
    } sbb_t;

    typedef struct packed {
        op_t                op;
        logic signed [42:0] ve;
        logic               big;
        logic               neg;
    } sbc_t;

    localparam logic signed [42:0] VMAX = 43'sd2147483647;
    localparam logic signed [42:0] VMIN = -43'sd2147483648;

    logic en;
    logic [DIV_LAT-1:0]  va_reg, vc_reg;
    logic [TERM_LAT-1:0] vb_reg;
    sba_t sba_reg [DIV_LAT];
    sbb_t sbb_reg [TERM_LAT];
    sbc_t sbc_reg [DIV_LAT];
    logic      rv_reg;
    out_item_t res_reg;

    logic [63:0] num_q, q_r, q_c, qc_eff, q_sel;
    logic [63:0] m_a, m_b, f_q, f_num;
    logic        neg_a, neg_b;
    sba_t        sba_in;
    sbb_t        sbb_in;
    sbc_t        sbc_in;
    logic signed [42:0] e_a, e_b, v_f, v;
    logic [40:0] f_mag;
    out_item_t   res_next;

    // The whole datapath moves when the output register can take an item.
    assign en  = !rv_reg || !result_stall;
    assign pop = en && !empty;

    assign num_q = {3'd0, head.s13, 44'd0} >> 17;

    tljp_div u_div_r (.clk, .en, .num(num_q), .den(head.pair_dist), .quo(q_r));
    tljp_div u_div_c (.clk, .en, .num(num_q), .den(head.cutoff),    .quo(q_c));

    always_comb
    begin
        sba_in.op        = head.op;
        sba_in.use_cut   = head.use_cut;
        sba_in.cut_zero  = head.cut_zero;
        sba_in.eps       = head.eps;
        sba_in.pair_dist = head.pair_dist;
    end

    // A zero cutoff divides to all ones, which is right unless sigma is zero too.
    assign qc_eff = sba_reg[DIV_LAT-1].cut_zero ? 64'd0 : q_c;
    assign q_sel  = sba_reg[DIV_LAT-1].use_cut ? qc_eff : q_r;

    tljp_term u_term_a (.clk, .en, .q(q_sel), .eps(sba_reg[DIV_LAT-1].eps),
                        .wsel(sba_reg[DIV_LAT-1].op == OP_FORCE), .m(m_a), .neg(neg_a));
    tljp_term u_term_b (.clk, .en, .q(qc_eff), .eps(sba_reg[DIV_LAT-1].eps),
                        .wsel(1'b0), .m(m_b), .neg(neg_b));

    always_comb
    begin
        sbb_in.op        = sba_reg[DIV_LAT-1].op;
        sbb_in.eps_sh    = sba_reg[DIV_LAT-1].eps[31:8];
        sbb_in.pair_dist = sba_reg[DIV_LAT-1].pair_dist;
    end

    always_comb
    begin
        e_a = to_signed(cap40(m_a), neg_a);
        e_b = to_signed(cap40(m_b), neg_b);
        sbc_in.op  = sbb_reg[TERM_LAT-1].op;
        sbc_in.big = |m_a[63:47];
        sbc_in.neg = neg_a;
        if (sbb_reg[TERM_LAT-1].op == OP_E_WCA)
        begin
            sbc_in.ve = e_a + $signed({19'd0, sbb_reg[TERM_LAT-1].eps_sh});
        end
        else
        begin
            sbc_in.ve = e_a - e_b;
        end
    end

    assign f_num = {m_a[47:0], 16'd0};

    tljp_div u_div_f (.clk, .en, .num(f_num), .den(sbb_reg[TERM_LAT-1].pair_dist),
                      .quo(f_q));

    always_comb
    begin
        f_mag = cap40(sbc_reg[DIV_LAT-1].big ? TOP : f_q);
        v_f   = to_signed(f_mag, sbc_reg[DIV_LAT-1].neg);
        res_next.overlap = 1'b0;
        unique case (sbc_reg[DIV_LAT-1].op) inside
            OP_OVERLAP:         v = VMAX;
            OP_E_WCA, OP_E_LJ:  v = sbc_reg[DIV_LAT-1].ve;
            OP_FORCE:           v = v_f;
            default:            v = '0;
        endcase
        if (sbc_reg[DIV_LAT-1].op == OP_OVERLAP)
        begin
            res_next.overlap = 1'b1;
        end
        if (v > VMAX)
        begin
            res_next.value     = 32'sh7FFF_FFFF;
            res_next.saturated = 1'b1;
        end
        else if (v < VMIN)
        begin
            res_next.value     = 32'sh8000_0000;
            res_next.saturated = 1'b1;
        end
        else
        begin
            res_next.value     = v[31:0];
            res_next.saturated = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sba_reg[0] <= sba_in;
            sbb_reg[0] <= sbb_in;
            sbc_reg[0] <= sbc_in;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                sba_reg[k] <= sba_reg[k-1];
                sbc_reg[k] <= sbc_reg[k-1];
            end
            for (int k = 1; k < TERM_LAT; k++)
            begin
                sbb_reg[k] <= sbb_reg[k-1];
            end
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= '0;
            vb_reg <= '0;
            vc_reg <= '0;
            rv_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= {va_reg[DIV_LAT-2:0], pop};
            vb_reg <= {vb_reg[TERM_LAT-2:0], va_reg[DIV_LAT-1]};
            vc_reg <= {vc_reg[DIV_LAT-2:0], vb_reg[TERM_LAT-1]};
            rv_reg <= vc_reg[DIV_LAT-1];
        end
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

// File: src/tljp_checker.sv
// ============================================================================
// tljp_checker
// Port-level checks on the pair kernel, bound to the top level.
// ============================================================================
module tljp_checker import tljp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      result_valid,
    input logic      result_stall,
    input out_item_t result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_overlap_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.overlap |->
            result.value == 32'sh7FFF_FFFF && !result.saturated)
        else $error("overlap result not at maximum");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            result.value == 32'sh7FFF_FFFF || result.value == 32'sh8000_0000)
        else $error("saturated result not at a range limit");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !result_valid)
        else $error("result shown right after reset");

endmodule

bind truncated_lj_pair_energy_force tljp_checker u_chk (.*);
